[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the controller core; they expect clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DPID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dpid_pkg.sv]
// ----------------------------------------------------------------------------
// dpid_pkg
// widths, register indexes, reset values and shared types of the dual pid
// drive controller
// ----------------------------------------------------------------------------
package dpid_pkg;

  localparam int POS_W  = 23;
  localparam int ERR_W  = 25;
  localparam int DIFF_W = 26;
  localparam int SUM_W  = 18;
  localparam int RAW_W  = 26;
  localparam int GAIN_W = 32;
  localparam int LIM_W  = 16;
  localparam int PWR_W  = 8;
  localparam int IDX_W  = 3;
  localparam int PE_W   = ERR_W + GAIN_W;
  localparam int PS_W   = SUM_W + GAIN_W;
  localparam int PD_W   = DIFF_W + GAIN_W;
  localparam int ACC_W  = PD_W + 2;
  localparam int MIX_W  = ACC_W + 1;
  localparam int FRAC_W = 29;
  localparam int PCT_W  = MIX_W - FRAC_W;

  localparam logic signed [PWR_W-1:0] PWR_MAX = 8'sd100;

  localparam logic signed [GAIN_W-1:0] KP_RST = 32'sd26843546;
  localparam logic signed [GAIN_W-1:0] KI_RST = 32'sd3;
  localparam logic signed [GAIN_W-1:0] KD_RST = 32'sd268435;
  localparam logic [LIM_W-1:0]         LIMIT_RST = 16'd1000;

  typedef enum logic [IDX_W-1:0] {
    REG_LAT_KP  = 3'd0,
    REG_LAT_KI  = 3'd1,
    REG_LAT_KD  = 3'd2,
    REG_TURN_KP = 3'd3,
    REG_TURN_KI = 3'd4,
    REG_TURN_KD = 3'd5,
    REG_LIMIT   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    gains_t           lat;
    gains_t           turn;
    logic [LIM_W-1:0] limit;
  } cfg_t;

  // error, error delta and clamped sum of one axis
  typedef struct packed {
    logic signed [ERR_W-1:0]  e;
    logic signed [DIFF_W-1:0] d;
    logic signed [SUM_W-1:0]  s;
  } axis_t;

endpackage

[hw/rtl/dpid_in_if.sv]
// ----------------------------------------------------------------------------
// dpid_in_if
// request channel carrying one control tick: wheel positions and targets
// ----------------------------------------------------------------------------
interface dpid_in_if import dpid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] left_position;
  logic signed [POS_W-1:0] right_position;
  logic signed [POS_W-1:0] lateral_target;
  logic signed [POS_W-1:0] turn_target;
  logic                    clear_sums;

  modport source (
    output valid, left_position, right_position, lateral_target, turn_target,
    output clear_sums,
    input  ready
  );

  modport sink (
    input  valid, left_position, right_position, lateral_target, turn_target,
    input  clear_sums,
    output ready
  );
endinterface

[hw/rtl/dpid_out_if.sv]
// ----------------------------------------------------------------------------
// dpid_out_if
// result channel: drive powers and the two errors of one tick
// ----------------------------------------------------------------------------
interface dpid_out_if import dpid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PWR_W-1:0] left_power;
  logic signed [PWR_W-1:0] right_power;
  logic signed [ERR_W-1:0] lateral_error;
  logic signed [ERR_W-1:0] turn_error;

  modport source (
    output valid, left_power, right_power, lateral_error, turn_error,
    input  ready
  );

  modport sink (
    input  valid, left_power, right_power, lateral_error, turn_error,
    output ready
  );
endinterface

[hw/rtl/dpid_cfg_if.sv]
// ----------------------------------------------------------------------------
// dpid_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface dpid_cfg_if import dpid_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/dpid_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dpid_cfg_regs
// gain and integral limit registers, written through the config channel
// ----------------------------------------------------------------------------
module dpid_cfg_regs import dpid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dpid_cfg_if.sink    cfg,
  output cfg_t        cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_LAT_KP:  cfg_nxt.lat.kp  = $signed(cfg.data);
        REG_LAT_KI:  cfg_nxt.lat.ki  = $signed(cfg.data);
        REG_LAT_KD:  cfg_nxt.lat.kd  = $signed(cfg.data);
        REG_TURN_KP: cfg_nxt.turn.kp = $signed(cfg.data);
        REG_TURN_KI: cfg_nxt.turn.ki = $signed(cfg.data);
        REG_TURN_KD: cfg_nxt.turn.kd = $signed(cfg.data);
        REG_LIMIT:   cfg_nxt.limit   = cfg.data[LIM_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lat.kp  <= KP_RST;
      cfg_r.lat.ki  <= KI_RST;
      cfg_r.lat.kd  <= KD_RST;
      cfg_r.turn.kp <= KP_RST;
      cfg_r.turn.ki <= KI_RST;
      cfg_r.turn.kd <= KD_RST;
      cfg_r.limit   <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hw/rtl/dpid_err_stage.sv]
// ----------------------------------------------------------------------------
// dpid_err_stage
// lateral and turn errors, deltas and clamped running sums; its registers
// hold the loop state (previous errors and sums)
// ----------------------------------------------------------------------------
module dpid_err_stage import dpid_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ld_i,
  input  logic signed [POS_W-1:0] left_i,
  input  logic signed [POS_W-1:0] right_i,
  input  logic signed [POS_W-1:0] lat_t_i,
  input  logic signed [POS_W-1:0] turn_t_i,
  input  logic                    clear_i,
  input  logic [LIM_W-1:0]        limit_i,
  output axis_t                   lat_o,
  output axis_t                   turn_o
);

  axis_t lat_r, lat_nxt;
  axis_t turn_r, turn_nxt;

  logic signed [ERR_W-1:0] pos_sum;
  logic signed [ERR_W-1:0] pos_dif;
  logic signed [ERR_W-1:0] lat_t2;
  logic signed [ERR_W-1:0] turn_t2;
  logic signed [RAW_W-1:0] lim;
  logic signed [SUM_W-1:0] lat_base;
  logic signed [SUM_W-1:0] turn_base;

  function automatic logic signed [SUM_W-1:0] next_sum(
    input logic signed [SUM_W-1:0] base,
    input logic signed [ERR_W-1:0] e,
    input logic signed [RAW_W-1:0] lim_v
  );
    logic signed [RAW_W-1:0] raw;
    raw = RAW_W'(base) + RAW_W'(e);
    if (raw > lim_v) begin
      return SUM_W'(lim_v);
    end else if (raw < -lim_v) begin
      return SUM_W'(-lim_v);
    end
    return SUM_W'(raw);
  endfunction

  always_comb begin
    pos_sum   = ERR_W'(left_i) + ERR_W'(right_i);
    pos_dif   = ERR_W'(left_i) - ERR_W'(right_i);
    lat_t2    = {lat_t_i[POS_W-1], lat_t_i, 1'b0};
    turn_t2   = {turn_t_i[POS_W-1], turn_t_i, 1'b0};
    // limit is in whole degrees, sums in half degrees
    lim       = $signed(RAW_W'({limit_i, 1'b0}));
    lat_base  = clear_i ? '0 : lat_r.s;
    turn_base = clear_i ? '0 : turn_r.s;

    lat_nxt.e  = lat_t2 - pos_sum;
    turn_nxt.e = turn_t2 - pos_dif;
    lat_nxt.d  = DIFF_W'(lat_nxt.e) - DIFF_W'(lat_r.e);
    turn_nxt.d = DIFF_W'(turn_nxt.e) - DIFF_W'(turn_r.e);
    lat_nxt.s  = next_sum(lat_base, lat_nxt.e, lim);
    turn_nxt.s = next_sum(turn_base, turn_nxt.e, lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r  <= '0;
      turn_r <= '0;
    end else if (ld_i) begin
      lat_r  <= lat_nxt;
      turn_r <= turn_nxt;
    end
  end

  assign lat_o  = lat_r;
  assign turn_o = turn_r;

endmodule

[hw/rtl/dpid_pid_term.sv]
// ----------------------------------------------------------------------------
// dpid_pid_term
// one pid term: three registered products, then their registered total
// ----------------------------------------------------------------------------
module dpid_pid_term import dpid_pkg::*; (
  input  logic                    clk,
  input  logic                    ld2_i,
  input  logic                    ld3_i,
  input  axis_t                   axis_i,
  input  gains_t                  gains_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic signed [ERR_W-1:0] err_o
);

  logic signed [PE_W-1:0]  pe_r, pe_nxt;
  logic signed [PS_W-1:0]  ps_r, ps_nxt;
  logic signed [PD_W-1:0]  pd_r, pd_nxt;
  logic signed [ERR_W-1:0] e2_r, e3_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  assign pe_nxt  = axis_i.e * gains_i.kp;
  assign ps_nxt  = axis_i.s * gains_i.ki;
  assign pd_nxt  = axis_i.d * gains_i.kd;
  assign acc_nxt = ACC_W'(pe_r) + ACC_W'(ps_r) + ACC_W'(pd_r);

  always_ff @(posedge clk) begin
    if (ld2_i) begin
      pe_r <= pe_nxt;
      ps_r <= ps_nxt;
      pd_r <= pd_nxt;
      e2_r <= axis_i.e;
    end
    if (ld3_i) begin
      acc_r <= acc_nxt;
      e3_r  <= e2_r;
    end
  end

  assign acc_o = acc_r;
  assign err_o = e3_r;

endmodule

[hw/rtl/dpid_mix.sv]
// ----------------------------------------------------------------------------
// dpid_mix
// left/right mixing, q.29 to whole percent toward zero, saturation, and the
// result register
// ----------------------------------------------------------------------------
module dpid_mix import dpid_pkg::*; (
  input  logic                    clk,
  input  logic                    ld_i,
  input  logic signed [ACC_W-1:0] lat_acc_i,
  input  logic signed [ACC_W-1:0] turn_acc_i,
  input  logic signed [ERR_W-1:0] lat_e_i,
  input  logic signed [ERR_W-1:0] turn_e_i,
  output logic signed [PWR_W-1:0] left_o,
  output logic signed [PWR_W-1:0] right_o,
  output logic signed [ERR_W-1:0] lat_e_o,
  output logic signed [ERR_W-1:0] turn_e_o
);

  localparam logic signed [MIX_W-1:0] BIAS = MIX_W'((64'd1 << FRAC_W) - 64'd1);

  logic signed [MIX_W-1:0] left_mix, right_mix;
  logic signed [PWR_W-1:0] left_r, left_nxt, right_r, right_nxt;
  logic signed [ERR_W-1:0] lat_e_r, turn_e_r;

  function automatic logic signed [PWR_W-1:0] to_pct(input logic signed [MIX_W-1:0] v);
    logic signed [MIX_W-1:0] biased;
    logic signed [PCT_W-1:0] q;
    biased = v;
    // negative values get a bias so the shift truncates toward zero
    if (v[MIX_W-1]) begin
      biased = v + BIAS;
    end
    q = PCT_W'(biased >>> FRAC_W);
    if (q > PCT_W'(PWR_MAX)) begin
      return PWR_MAX;
    end else if (q < -PCT_W'(PWR_MAX)) begin
      return -PWR_MAX;
    end
    return PWR_W'(q);
  endfunction

  assign left_mix  = MIX_W'(lat_acc_i) + MIX_W'(turn_acc_i);
  assign right_mix = MIX_W'(lat_acc_i) - MIX_W'(turn_acc_i);
  assign left_nxt  = to_pct(left_mix);
  assign right_nxt = to_pct(right_mix);

  always_ff @(posedge clk) begin
    if (ld_i) begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      lat_e_r  <= lat_e_i;
      turn_e_r <= turn_e_i;
    end
  end

  assign left_o   = left_r;
  assign right_o  = right_r;
  assign lat_e_o  = lat_e_r;
  assign turn_e_o = turn_e_r;

endmodule

[hw/rtl/dual_pid_drive_controller_core.sv]
// ----------------------------------------------------------------------------
// dual_pid_drive_controller_core
// lateral and turn pid loops for a differential-drive base
// ----------------------------------------------------------------------------
// usage:
//   in_chan takes one request per control tick: both encoder positions, the
//   lateral and turn targets and clear_sums, which zeroes both error sums
//   before that tick. out_chan returns exactly one result per request: left
//   and right power in percent (-100..100) plus the lateral and turn errors
//   in half degrees. cfg_chan writes the six q3.28 gains and the integral
//   limit by index; it is always ready, indexes past the list are dropped,
//   and it must only be used while no request is in flight.
//   throughput: one request per cycle while out_chan is not stalled; the sums
//   and previous errors live in the error stage and are updated as each request
//   enters it, so ticks chain without a gap. the path is input reg, error stage,
//   product regs, pid totals, result reg.
//   reset: all stages empty, sums and previous errors zero, gains and limit
//   at their defaults.
//   stall: a held result keeps its data; each stage moves only into a free
//   or draining slot, so up to five requests sit in the pipe before
//   in_chan.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_pid_drive_controller_core import dpid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dpid_in_if.sink     in_chan,
  dpid_out_if.source  out_chan,
  dpid_cfg_if.sink    cfg_chan
);

  // stage valids, input register through result register
  logic in_v_r, in_v_nxt;
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic s3_v_r, s3_v_nxt;
  logic out_v_r, out_v_nxt;

  // a stage can take a request when empty or when it hands its own on
  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic ld0, ld1, ld2, ld3, ld4;

  // input register
  logic signed [POS_W-1:0] left_r, right_r, lat_t_r, turn_t_r;
  logic                    clear_r;

  cfg_t  cfg;
  axis_t lat_ax, turn_ax;

  logic signed [ACC_W-1:0] lat_acc, turn_acc;
  logic signed [ERR_W-1:0] lat_e3, turn_e3;
  logic signed [PWR_W-1:0] left_w, right_w;
  logic signed [ERR_W-1:0] lat_e_w, turn_e_w;
  logic signed [RAW_W-1:0] lim_chk;
  logic                    lat_s_ok, turn_s_ok, pwr_ok, s1_stall;

  // ready chain from the output back
  assign rdy4 = !out_v_r || out_chan.ready;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign rdy0 = !in_v_r || rdy1;

  assign ld0 = in_chan.valid && rdy0;
  assign ld1 = in_v_r && rdy1;
  assign ld2 = s1_v_r && rdy2;
  assign ld3 = s2_v_r && rdy3;
  assign ld4 = s3_v_r && rdy4;

  always_comb begin
    in_v_nxt  = ld0 || (in_v_r && !rdy1);
    s1_v_nxt  = ld1 || (s1_v_r && !rdy2);
    s2_v_nxt  = ld2 || (s2_v_r && !rdy3);
    s3_v_nxt  = ld3 || (s3_v_r && !rdy4);
    out_v_nxt = ld4 || (out_v_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ld0) begin
      left_r   <= in_chan.left_position;
      right_r  <= in_chan.right_position;
      lat_t_r  <= in_chan.lateral_target;
      turn_t_r <= in_chan.turn_target;
      clear_r  <= in_chan.clear_sums;
    end
  end

  assign in_chan.ready = rdy0;

  dpid_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_chan),
    .cfg_o (cfg)
  );

  // loop state advances exactly once per request, here
  dpid_err_stage u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_i     (ld1),
    .left_i   (left_r),
    .right_i  (right_r),
    .lat_t_i  (lat_t_r),
    .turn_t_i (turn_t_r),
    .clear_i  (clear_r),
    .limit_i  (cfg.limit),
    .lat_o    (lat_ax),
    .turn_o   (turn_ax)
  );

  dpid_pid_term u_lat_pid (
    .clk     (clk),
    .ld2_i   (ld2),
    .ld3_i   (ld3),
    .axis_i  (lat_ax),
    .gains_i (cfg.lat),
    .acc_o   (lat_acc),
    .err_o   (lat_e3)
  );

  dpid_pid_term u_turn_pid (
    .clk     (clk),
    .ld2_i   (ld2),
    .ld3_i   (ld3),
    .axis_i  (turn_ax),
    .gains_i (cfg.turn),
    .acc_o   (turn_acc),
    .err_o   (turn_e3)
  );

  dpid_mix u_mix (
    .clk        (clk),
    .ld_i       (ld4),
    .lat_acc_i  (lat_acc),
    .turn_acc_i (turn_acc),
    .lat_e_i    (lat_e3),
    .turn_e_i   (turn_e3),
    .left_o     (left_w),
    .right_o    (right_w),
    .lat_e_o    (lat_e_w),
    .turn_e_o   (turn_e_w)
  );

  assign out_chan.valid         = out_v_r;
  assign out_chan.left_power    = left_w;
  assign out_chan.right_power   = right_w;
  assign out_chan.lateral_error = lat_e_w;
  assign out_chan.turn_error    = turn_e_w;

  // clamp bound in half degrees, for the checks below; the user keeps the
  // limit unchanged while a request is in flight; the block leaves it unenforced
  assign lim_chk   = $signed(RAW_W'({cfg.limit, 1'b0}));
  assign lat_s_ok  = (RAW_W'(lat_ax.s) <= lim_chk) && (RAW_W'(lat_ax.s) >= -lim_chk);
  assign turn_s_ok = (RAW_W'(turn_ax.s) <= lim_chk) && (RAW_W'(turn_ax.s) >= -lim_chk);
  assign pwr_ok    = (left_w <= PWR_MAX) && (left_w >= -PWR_MAX) &&
                     (right_w <= PWR_MAX) && (right_w >= -PWR_MAX);
  assign s1_stall  = s1_v_r && !rdy2;

  `DPID_ASSERT_NEXT(a_sum_in_limit, ld1, lat_s_ok && turn_s_ok, "error sum outside the limit")
  `DPID_ASSERT_NEXT(a_state_held, s1_stall, s1_v_r && $stable({lat_ax, turn_ax}), "state moved")
  `DPID_ASSERT_NOW(a_power_range, out_v_r, pwr_ok, "drive power outside +/-100")

endmodule
